FILE: sv/tpt_pkg.sv
// shared types and constants of the tlb page table translator
// used by tpt_ctrl, tpt_datapath and tlb_page_table_translator; no dependencies
package tpt_pkg;

    // fixed field widths and the frame limit
    localparam int VA_W        = 16;
    localparam int FRAME_W     = 8;
    localparam int CNT_W       = 32;
    localparam int FRAME_LIMIT = 256;
    localparam int TDATA_W     = 120;
    localparam int TUSER_W     = 2;

    // parameter defaults
    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int OFFSET_BITS_DEF = 8;

    // controller to datapath commands
    typedef struct packed {
        logic clear_step;   // write one cleared page table entry
        logic load_direct;  // take a beat, page by mask, start lookup
        logic load_raw;     // take a beat, start page reduction
        logic reduce_step;  // one step of the page reduction
        logic match;        // lookup with the reduced page
        logic commit;       // update state and load the output register
    } tpt_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;   // last page table entry is being cleared
        logic reduce_last;  // last reduction step is being done
        logic out_busy;     // output register holds a beat not yet taken
    } tpt_sts_t;

endpackage

FILE: sv/tpt_ctrl.sv
// controller state machine of the tlb page table translator
// depends on tpt_pkg for the command and status structs
module tpt_ctrl #(
    parameter int PAGE_COUNT = tpt_pkg::PAGE_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tpt_pkg::tpt_sts_t sts,
    output tpt_pkg::tpt_cmd_t cmd
);

    localparam bit POW2 = ((PAGE_COUNT & (PAGE_COUNT - 1)) == 0);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_MATCH  = 3'd3;
    localparam logic [2:0] S_LOOK   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (POW2)
                    begin
                        cmd.load_direct = 1'b1;
                        state_next      = S_LOOK;
                    end
                    else
                    begin
                        cmd.load_raw = 1'b1;
                        state_next   = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                cmd.reduce_step = 1'b1;
                if (sts.reduce_last)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/tpt_datapath.sv
// datapath of the tlb page table translator: tlb lanes, page table memory,
// page reduction, counters and output register; depends on tpt_pkg
module tpt_datapath #(
    parameter int TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = tpt_pkg::PAGE_COUNT_DEF,
    parameter int OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tpt_pkg::tpt_cmd_t           cmd,
    output tpt_pkg::tpt_sts_t           sts,
    input  logic [tpt_pkg::VA_W-1:0]    in_va,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tpt_pkg::TDATA_W-1:0] out_data,
    output logic [tpt_pkg::TUSER_W-1:0] out_user
);

    localparam int FW     = tpt_pkg::FRAME_W;
    localparam int CW     = tpt_pkg::CNT_W;
    localparam int VPN_W  = tpt_pkg::VA_W - OFFSET_BITS;
    localparam int VPN_WX = (VPN_W > 0) ? VPN_W : 1;
    localparam int RED_W  = VPN_WX + 13;
    localparam int MUL_W  = VPN_WX + tpt_pkg::VA_W;
    localparam int KW     = 2;
    localparam int PG_W   = $clog2(PAGE_COUNT);
    localparam int TW     = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int NW     = $clog2(TLB_ENTRIES + 1);
    localparam int PA_W   = FW + 16;

    localparam logic [RED_W-1:0] PG_MASK  = RED_W'((1 << PG_W) - 1);
    localparam logic [RED_W-1:0] PG_DIV   = RED_W'(PAGE_COUNT);
    localparam logic [MUL_W-1:0] RECIP    = MUL_W'((1 << tpt_pkg::VA_W) / PAGE_COUNT);
    localparam logic [KW-1:0]    K_MUL    = 2'd2;
    localparam logic [KW-1:0]    K_SUB    = 2'd1;
    localparam logic [KW-1:0]    K_FIX    = 2'd0;
    localparam logic [PG_W-1:0]  CLR_LAST = PG_W'(PAGE_COUNT - 1);
    localparam logic [NW-1:0]    FULL     = NW'(TLB_ENTRIES);
    localparam logic [8:0]       FR_LIMIT = 9'(tpt_pkg::FRAME_LIMIT);

    // tlb lanes, oldest at entry 0
    logic [FW-1:0] tlb_page_reg  [TLB_ENTRIES];
    logic [FW-1:0] tlb_frame_reg [TLB_ENTRIES];
    logic [FW-1:0] above_page    [TLB_ENTRIES];
    logic [FW-1:0] above_frame   [TLB_ENTRIES];
    logic [NW-1:0] fill_reg;

    // page table memory: mapped bit over frame
    logic [FW:0]   pt_mem [PAGE_COUNT];
    logic [FW:0]   pt_rd_reg;
    logic [PG_W-1:0] clr_addr_reg;

    // per item registers
    logic [RED_W-1:0]       rem_reg;
    logic [VPN_WX-1:0]      quot_reg;
    logic [KW-1:0]          red_k_reg;
    logic [PG_W-1:0]        page_reg;
    logic [FW-1:0]          page8_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [TLB_ENTRIES-1:0] match_reg;

    logic [8:0]    nff_reg;
    logic [CW-1:0] trans_cnt_reg;
    logic [CW-1:0] hit_cnt_reg;
    logic [CW-1:0] fault_cnt_reg;

    logic                   out_valid_reg;
    logic [15:0]            out_pa_reg;
    logic [FW-1:0]          out_frame_reg;
    logic                   out_hit_reg;
    logic                   out_fault_reg;
    logic [CW-1:0]          out_trans_reg;
    logic [CW-1:0]          out_hits_reg;
    logic [CW-1:0]          out_faults_reg;

    logic [RED_W-1:0]       vpn_ext;
    logic [RED_W-1:0]       page_full;
    logic [MUL_W-1:0]       quot_prod;
    logic [RED_W-1:0]       quot_back;
    logic                   lookup;
    logic [TLB_ENTRIES-1:0] match_next;
    logic [TW-1:0]          found;
    logic                   hit;
    logic                   mapped;
    logic                   fault;
    logic [8:0]             nff_eff;
    logic [FW-1:0]          frame;
    logic                   shift;
    logic [NW-1:0]          remove_at;
    logic [NW-1:0]          last;
    logic [NW-1:0]          fill_next;
    logic [PA_W-1:0]        pa_wide;
    logic                   out_take;

    // page number of the incoming address, and the page used for lookup
    assign vpn_ext   = RED_W'(in_va >> OFFSET_BITS);
    assign page_full = cmd.load_direct ? (vpn_ext & PG_MASK) : rem_reg;
    assign lookup    = cmd.load_direct | cmd.match;

    // page modulo PAGE_COUNT: reciprocal quotient estimate, low by at most one,
    // then subtract quotient times PAGE_COUNT, then one correcting subtract
    assign quot_prod = MUL_W'(rem_reg[VPN_WX-1:0]) * RECIP;
    assign quot_back = RED_W'(quot_reg) * PG_DIV;

    // parallel compare against the valid tlb entries
    always_comb
    begin
        for (int k = 0; k < TLB_ENTRIES; k++)
        begin
            match_next[k] = (NW'(k) < fill_reg) && (tlb_page_reg[k] == page_full[FW-1:0]);
        end
    end

    // item registers and reduction steps
    always_ff @(posedge clk)
    begin
        if (cmd.load_direct || cmd.load_raw)
        begin
            offset_reg <= in_va[OFFSET_BITS-1:0];
        end
        if (cmd.load_raw)
        begin
            rem_reg   <= vpn_ext;
            red_k_reg <= K_MUL;
        end
        else if (cmd.reduce_step)
        begin
            case (red_k_reg)
                K_MUL:
                begin
                    quot_reg <= quot_prod[MUL_W-1:tpt_pkg::VA_W];
                end
                K_SUB:
                begin
                    rem_reg <= rem_reg - quot_back;
                end
                K_FIX:
                begin
                    if (rem_reg >= PG_DIV)
                    begin
                        rem_reg <= rem_reg - PG_DIV;
                    end
                end
                default:
                begin
                end
            endcase
            red_k_reg <= red_k_reg - 1'b1;
        end
        if (lookup)
        begin
            page_reg  <= page_full[PG_W-1:0];
            page8_reg <= page_full[FW-1:0];
            match_reg <= match_next;
        end
    end

    // page table memory: clearing pass, lookup read, fault write
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            pt_mem[clr_addr_reg] <= '0;
        end
        else if (cmd.commit && fault)
        begin
            pt_mem[page_reg] <= {1'b1, nff_eff[FW-1:0]};
        end
        if (lookup)
        begin
            pt_rd_reg <= pt_mem[page_full[PG_W-1:0]];
        end
    end

    // clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // first matching entry
    always_comb
    begin
        found = '0;
        for (int k = TLB_ENTRIES - 1; k >= 0; k--)
        begin
            if (match_reg[k])
            begin
                found = TW'(k);
            end
        end
    end

    // translation result
    assign hit     = |match_reg;
    assign mapped  = pt_rd_reg[FW];
    assign fault   = !hit && !mapped;
    assign nff_eff = (nff_reg >= FR_LIMIT) ? 9'd0 : nff_reg;
    assign frame   = hit ? tlb_frame_reg[found] : (mapped ? pt_rd_reg[FW-1:0] : nff_eff[FW-1:0]);
    assign pa_wide = (PA_W'(frame) << OFFSET_BITS) | PA_W'(offset_reg);

    // lru update plan: drop the hit entry, or the oldest when full, append at the end
    assign shift     = hit || (fill_reg == FULL);
    assign remove_at = hit ? NW'(found) : '0;
    assign last      = shift ? fill_reg - 1'b1 : fill_reg;
    assign fill_next = shift ? fill_reg : fill_reg + 1'b1;

    // neighbor above each lane
    always_comb
    begin
        for (int k = 0; k < TLB_ENTRIES; k++)
        begin
            above_page[k]  = '0;
            above_frame[k] = '0;
        end
        for (int k = 0; k < TLB_ENTRIES - 1; k++)
        begin
            above_page[k]  = tlb_page_reg[k + 1];
            above_frame[k] = tlb_frame_reg[k + 1];
        end
    end

    // tlb lanes
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            for (int k = 0; k < TLB_ENTRIES; k++)
            begin
                if (NW'(k) == last)
                begin
                    tlb_page_reg[k]  <= page8_reg;
                    tlb_frame_reg[k] <= frame;
                end
                else if (shift && (NW'(k) >= remove_at) && (NW'(k) < last))
                begin
                    tlb_page_reg[k]  <= above_page[k];
                    tlb_frame_reg[k] <= above_frame[k];
                end
            end
        end
    end

    // fill count, free frame pointer and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            nff_reg       <= '0;
            trans_cnt_reg <= '0;
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            fill_reg <= fill_next;
            if (fault)
            begin
                nff_reg <= nff_eff + 9'd1;
            end
            if (trans_cnt_reg != '1)
            begin
                trans_cnt_reg <= trans_cnt_reg + 1'b1;
            end
            if (hit && (hit_cnt_reg != '1))
            begin
                hit_cnt_reg <= hit_cnt_reg + 1'b1;
            end
            if (fault && (fault_cnt_reg != '1))
            begin
                fault_cnt_reg <= fault_cnt_reg + 1'b1;
            end
        end
    end

    // output beat valid
    assign out_take = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_pa_reg     <= pa_wide[15:0];
            out_frame_reg  <= frame;
            out_hit_reg    <= hit;
            out_fault_reg  <= fault;
            out_trans_reg  <= (trans_cnt_reg != '1) ? trans_cnt_reg + 1'b1 : trans_cnt_reg;
            out_hits_reg   <= (hit && (hit_cnt_reg != '1)) ? hit_cnt_reg + 1'b1 : hit_cnt_reg;
            out_faults_reg <= (fault && (fault_cnt_reg != '1)) ? fault_cnt_reg + 1'b1
                                                               : fault_cnt_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {out_faults_reg, out_hits_reg, out_trans_reg, out_frame_reg, out_pa_reg};
    assign out_user  = {out_fault_reg, out_hit_reg};

    // status to the controller
    assign sts.clear_last  = (clr_addr_reg == CLR_LAST);
    assign sts.reduce_last = (red_k_reg == K_FIX);
    assign sts.out_busy    = out_valid_reg && !out_ready;

endmodule

FILE: sv/tlb_page_table_translator.sv
// demand-paged address translator with an lru ordered tlb
// an accepted address is looked up in the tlb and the page table, then committed
// to the output register once that is free; unless PAGE_COUNT is a power of two,
// the page is first reduced modulo PAGE_COUNT by multiply, subtract and fix steps
// no new address is taken until the last one is committed; at reset a clearing pass
// runs over every page table entry, tready low until it ends; depends on tpt_pkg, tpt_ctrl, tpt_datapath
module tlb_page_table_translator #(
    parameter int TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = tpt_pkg::PAGE_COUNT_DEF,
    parameter int OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [15:0] virtual_address
    input  logic [tpt_pkg::VA_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [15:0] physical_address, [23:16] frame, [55:24] translated_count,
    // [87:56] hit_count, [119:88] fault_count
    output logic [tpt_pkg::TDATA_W-1:0] m_axis_tdata,
    // [0] tlb_hit, [1] page_fault
    output logic [tpt_pkg::TUSER_W-1:0] m_axis_tuser
);

    tpt_pkg::tpt_cmd_t cmd;
    tpt_pkg::tpt_sts_t sts;

    // controller
    tpt_ctrl #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    tpt_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_COUNT  (PAGE_COUNT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_va     (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

FILE: verif/tlb_page_table_translator_tb.sv
// self-checking testbench of the tlb page table translator: directed and random addresses
// under three idle patterns, checked beat by beat against a behavioral translation model
// depends on tpt_pkg and tlb_page_table_translator
module tlb_page_table_translator_tb;

    localparam int  VA_W        = tpt_pkg::VA_W;
    localparam int  FRAME_W     = tpt_pkg::FRAME_W;
    localparam int  CNT_W       = tpt_pkg::CNT_W;
    localparam int  FRAME_LIMIT = tpt_pkg::FRAME_LIMIT;
    localparam int  TDATA_W     = tpt_pkg::TDATA_W;
    localparam int  TUSER_W     = tpt_pkg::TUSER_W;
    localparam int  TLB_DEPTH   = tpt_pkg::TLB_ENTRIES_DEF;
    localparam int  PAGES       = tpt_pkg::PAGE_COUNT_DEF;
    localparam int  OFS_W       = tpt_pkg::OFFSET_BITS_DEF;
    localparam int  RAND_ITEMS  = 230;
    localparam int  MAX_REPORTS = 10;
    localparam time RUN_LIMIT   = 64'd8000000;

    // one expected or observed translation beat
    typedef struct packed {
        logic [VA_W-1:0]    phys_addr;
        logic [FRAME_W-1:0] frame;
        logic               tlb_hit;
        logic               page_fault;
        logic [CNT_W-1:0]   translated;
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   faults;
    } xlate_t;

    // translation model plus the queue of outstanding translations
    class translation_scoreboard;
        logic [FRAME_W-1:0] tlb_page [TLB_DEPTH];
        logic [FRAME_W-1:0] tlb_frame [TLB_DEPTH];
        int unsigned        tlb_fill;
        bit                 mapped [PAGES];
        logic [FRAME_W-1:0] page_frame [PAGES];
        logic [8:0]         next_free;
        logic [CNT_W-1:0]   translated_total;
        logic [CNT_W-1:0]   hit_total;
        logic [CNT_W-1:0]   fault_total;
        xlate_t             pending_xlations [$];
        int unsigned        mismatches;

        function new();
            tlb_fill         = 0;
            next_free        = '0;
            translated_total = '0;
            hit_total        = '0;
            fault_total      = '0;
            mismatches       = 0;
            foreach (mapped[i])
                mapped[i] = 1'b0;
        endfunction

        function int unsigned outstanding();
            return pending_xlations.size();
        endfunction

        // advance the model by one accepted address and queue its translation
        function void note_address(input logic [VA_W-1:0] va);
            xlate_t             want;
            logic [OFS_W-1:0]   offset;
            logic [FRAME_W-1:0] page;
            logic [FRAME_W-1:0] frame;
            bit                 hit;
            bit                 fault;
            int unsigned        slot;
            offset = va[OFS_W-1:0];
            page   = va[VA_W-1:OFS_W];
            frame  = '0;
            hit    = 1'b0;
            fault  = 1'b0;
            slot   = 0;

            // tlb lookup, first valid match wins
            for (int i = 0; i < tlb_fill; i++)
            begin
                if (!hit && tlb_page[i] == page)
                begin
                    hit   = 1'b1;
                    slot  = i;
                    frame = tlb_frame[i];
                end
            end

            // page table, then demand allocation
            if (!hit)
            begin
                if (mapped[page])
                    frame = page_frame[page];
                else
                begin
                    if (next_free >= FRAME_LIMIT)
                        next_free = '0;
                    frame            = next_free[FRAME_W-1:0];
                    next_free        = next_free + 1'b1;
                    mapped[page]     = 1'b1;
                    page_frame[page] = frame;
                    fault            = 1'b1;
                end
            end

            // lru order: drop the hit entry or the oldest one when full
            if (hit || tlb_fill >= TLB_DEPTH)
            begin
                for (int k = (hit ? slot : 0); k + 1 < tlb_fill; k++)
                begin
                    tlb_page[k]  = tlb_page[k + 1];
                    tlb_frame[k] = tlb_frame[k + 1];
                end
                tlb_fill--;
            end
            tlb_page[tlb_fill]  = page;
            tlb_frame[tlb_fill] = frame;
            tlb_fill++;

            // saturating counters
            if (translated_total != '1)
                translated_total++;
            if (hit && hit_total != '1)
                hit_total++;
            if (fault && fault_total != '1)
                fault_total++;

            want.phys_addr  = {frame, offset};
            want.frame      = frame;
            want.tlb_hit    = hit;
            want.page_fault = fault;
            want.translated = translated_total;
            want.hits       = hit_total;
            want.faults     = fault_total;
            pending_xlations.push_back(want);
        endfunction

        // compare one output beat with the oldest outstanding translation
        function void check_translation(input logic [TDATA_W-1:0] data,
                                        input logic [TUSER_W-1:0] user);
            xlate_t got;
            xlate_t want;
            got.phys_addr  = data[15:0];
            got.frame      = data[23:16];
            got.translated = data[55:24];
            got.hits       = data[87:56];
            got.faults     = data[119:88];
            got.tlb_hit    = user[0];
            got.page_fault = user[1];

            if (pending_xlations.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: output beat with nothing outstanding, pa %h frame %h",
                             $time, got.phys_addr, got.frame);
                return;
            end
            want = pending_xlations.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t: mismatch exp pa %h fr %h hit %b flt %b cnt %0d/%0d/%0d",
                             $time, want.phys_addr, want.frame, want.tlb_hit,
                             want.page_fault, want.translated, want.hits, want.faults);
                    $display("%0t:          act pa %h fr %h hit %b flt %b cnt %0d/%0d/%0d",
                             $time, got.phys_addr, got.frame, got.tlb_hit,
                             got.page_fault, got.translated, got.hits, got.faults);
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [VA_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [TUSER_W-1:0]   m_axis_tuser;

    translation_scoreboard xlate_sb;
    int unsigned           src_idle_pct;
    int unsigned           sink_stall_pct;
    int unsigned           addr_sent;
    logic [FRAME_W-1:0]    hot_pages [24];

    tlb_page_table_translator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // free-running clock
    always #10 clk = ~clk;

    // receiver back-pressure
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            xlate_sb.check_translation(m_axis_tdata, m_axis_tuser);
    end

    // hard stop
    initial
    begin
        #(RUN_LIMIT);
        $display("tlb_page_table_translator_tb: errors");
        $finish;
    end

    // drive one address beat; called and returning on a falling edge
    task automatic send_address(input logic [VA_W-1:0] va);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= va;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        xlate_sb.note_address(va);
        addr_sent++;
        @(negedge clk);
    endtask

    // random address: mostly pages of a hot set larger than the tlb, some tight reuse,
    // the rest anywhere in the address space
    task automatic send_random_address();
        int unsigned        pick;
        logic [FRAME_W-1:0] page;
        pick = $urandom_range(99);
        if (pick < 55)
            page = hot_pages[$urandom_range(23)];
        else if (pick < 80)
            page = hot_pages[$urandom_range(7)];
        else
            page = FRAME_W'($urandom_range(PAGES - 1));
        send_address({page, 8'($urandom_range(255))});
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        src_idle_pct   = 36;
        sink_stall_pct = 65;
        addr_sent      = 0;
        xlate_sb       = new();
        foreach (hot_pages[i])
            hot_pages[i] = FRAME_W'($urandom_range(PAGES - 1));

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: address extremes, hits on both, fill the tlb
        send_address(16'h0000);
        send_address(16'hFFFF);
        send_address(16'h00FF);
        send_address(16'hFF00);
        for (int p = 1; p <= 14; p++)
            send_address({8'(p), 8'(p * 17)});
        // eviction of the oldest entry, then a page table hit for the evicted page
        send_address(16'h8033);
        send_address(16'h0012);
        // hit in the middle of the lru order
        send_address(16'h07AA);
        send_address(16'h5555);
        send_address(16'hAAAA);

        // random phases with three idle patterns
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct   = 36;
                    sink_stall_pct = 65;
                end
                1:
                begin
                    src_idle_pct   = 65;
                    sink_stall_pct = 36;
                end
                default:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < RAND_ITEMS; n++)
                send_random_address();
        end
        s_axis_tvalid <= 1'b0;

        // drain
        while (xlate_sb.outstanding() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("translated %0d addresses: %0d tlb hits, %0d page faults, %0d mismatches",
                 addr_sent, xlate_sb.hit_total, xlate_sb.fault_total, xlate_sb.mismatches);
        $display("idle patterns: sender 36/receiver 65, sender 65/receiver 36, no idling");
        if (xlate_sb.mismatches == 0 && xlate_sb.outstanding() == 0)
            $display("tlb_page_table_translator_tb: clean");
        else
            $display("tlb_page_table_translator_tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
sv/tpt_pkg.sv
sv/tpt_ctrl.sv
sv/tpt_datapath.sv
sv/tlb_page_table_translator.sv
verif/tlb_page_table_translator_tb.sv
